// ===== hw/rtl/socks5_handshake_parser_macros.svh =====
// assertion helpers for the top-level parser rtl
`ifndef SOCKS5_HANDSHAKE_PARSER_MACROS_SVH
`define SOCKS5_HANDSHAKE_PARSER_MACROS_SVH

// checked outside reset
`define SOCKS5HP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SOCKS5HP_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/socks5hp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package socks5hp_pkg;

   typedef enum logic [1:0] {
      CMD_DATA    = 2'd0,
      CMD_NEW     = 2'd1,
      CMD_OUTCOME = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      KIND_REPLY    = 3'd0,
      KIND_ADDRESS  = 3'd1,
      KIND_TARGET   = 3'd2,
      KIND_PAYLOAD  = 3'd3,
      KIND_CLOSED   = 3'd4,
      KIND_DIVERTED = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ATYPE_IPV4   = 2'd0,
      ATYPE_DOMAIN = 2'd1,
      ATYPE_IPV6   = 2'd2
   } atype_type;

   typedef enum logic [2:0] {
      REASON_NONE         = 3'd0,
      REASON_BAD_GREETING = 3'd1,
      REASON_NO_AUTH      = 3'd2,
      REASON_BAD_REQUEST  = 3'd3,
      REASON_CMD_UNSUPP   = 3'd4,
      REASON_ATYPE_UNSUPP = 3'd5,
      REASON_TUNNEL_FAIL  = 3'd6
   } reason_type;

   typedef enum logic [1:0] {
      MODE_UNKNOWN = 2'd0,
      MODE_SOCKS   = 2'd1,
      MODE_DIVERT  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      PH_GREETING = 3'd0,
      PH_REQUEST  = 3'd1,
      PH_WAIT     = 3'd2,
      PH_OPEN     = 3'd3,
      PH_CLOSED   = 3'd4
   } phase_type;

   // work orders handed from front to back
   typedef enum logic [2:0] {
      OP_SINGLE      = 3'd0,
      OP_SHORT       = 3'd1,
      OP_SHORT_CLOSE = 3'd2,
      OP_LONG        = 3'd3,
      OP_LONG_CLOSE  = 3'd4
   } op_type;

   typedef struct packed {
      op_type     op;
      kind_type   kind;
      logic [15:0] value;
      atype_type  atype;
      reason_type reason;
      logic [7:0] code;
   } action_type;

   localparam logic [7:0] SOCKS_VER     = 8'h05;
   localparam logic [7:0] METHOD_NOAUTH = 8'h00;
   localparam logic [7:0] REQ_CONNECT   = 8'h01;
   localparam logic [7:0] ATYP_IPV4     = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
   localparam logic [7:0] ATYP_IPV6     = 8'h04;
   localparam logic [7:0] IPV4_LEN      = 8'd4;
   localparam logic [7:0] IPV6_LEN      = 8'd16;

   localparam logic [7:0] REP_OK        = 8'h00;
   localparam logic [7:0] REP_FAIL      = 8'h01;
   localparam logic [7:0] REP_UNREACH   = 8'h04;
   localparam logic [7:0] REP_CMD       = 8'h07;
   localparam logic [7:0] REP_ATYPE     = 8'h08;
   localparam logic [7:0] REP_NOAUTH    = 8'hFF;

   localparam logic [3:0] SHORT_LEN     = 4'd2;
   localparam logic [3:0] LONG_LEN      = 4'd10;

   function automatic atype_type atype_of(input logic [7:0] code);
      if (code == ATYP_DOMAIN) begin
         return ATYPE_DOMAIN;
      end else if (code == ATYP_IPV6) begin
         return ATYPE_IPV6;
      end
      return ATYPE_IPV4;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/socks5hp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module socks5hp_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [1:0]               req_command,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_connected,
   input  wire logic                     q_full,
   output logic                          q_push,
   output socks5hp_pkg::action_type      q_action
);

   socks5hp_pkg::mode_type  mode_ff, mode_in;
   socks5hp_pkg::phase_type phase_ff, phase_in;
   logic [8:0] idx_ff, idx_in;
   logic [7:0] methods_ff, methods_in;
   logic       noauth_ff, noauth_in;
   logic [7:0] req_kind_ff, req_kind_in;
   logic [7:0] addr_code_ff, addr_code_in;
   logic [7:0] addr_size_ff, addr_size_in;
   logic [7:0] port_high_ff, port_high_in;

   logic                   accept;
   logic [8:0]             idx_inc;
   logic [7:0]             meth_dec;
   logic [9:0]             addr_start;
   logic [9:0]             addr_end;
   logic [9:0]             idx_wide;
   socks5hp_pkg::mode_type mode_eff;
   socks5hp_pkg::atype_type at;

   function automatic socks5hp_pkg::action_type make_act(
      input socks5hp_pkg::op_type     op,
      input socks5hp_pkg::kind_type   kind,
      input logic [15:0]              value,
      input socks5hp_pkg::atype_type  atype,
      input socks5hp_pkg::reason_type reason,
      input logic [7:0]               code
   );
      socks5hp_pkg::action_type a;
      a.op     = op;
      a.kind   = kind;
      a.value  = value;
      a.atype  = atype;
      a.reason = reason;
      a.code   = code;
      return a;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= socks5hp_pkg::MODE_UNKNOWN;
         phase_ff     <= socks5hp_pkg::PH_GREETING;
         idx_ff       <= '0;
         methods_ff   <= '0;
         noauth_ff    <= 1'b0;
         req_kind_ff  <= '0;
         addr_code_ff <= '0;
         addr_size_ff <= '0;
         port_high_ff <= '0;
      end else begin
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         methods_ff   <= methods_in;
         noauth_ff    <= noauth_in;
         req_kind_ff  <= req_kind_in;
         addr_code_ff <= addr_code_in;
         addr_size_ff <= addr_size_in;
         port_high_ff <= port_high_in;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      methods_in   = methods_ff;
      noauth_in    = noauth_ff;
      req_kind_in  = req_kind_ff;
      addr_code_in = addr_code_ff;
      addr_size_in = addr_size_ff;
      port_high_in = port_high_ff;
      q_push       = 1'b0;
      q_action     = make_act(socks5hp_pkg::OP_SINGLE, socks5hp_pkg::KIND_REPLY, 16'd0,
                              socks5hp_pkg::ATYPE_IPV4, socks5hp_pkg::REASON_NONE, 8'd0);

      idx_inc    = (idx_ff != 9'd511) ? idx_ff + 9'd1 : idx_ff;
      meth_dec   = methods_ff - 8'd1;
      addr_start = (addr_code_ff == socks5hp_pkg::ATYP_DOMAIN) ? 10'd5 : 10'd4;
      addr_end   = addr_start + {2'b00, addr_size_ff};
      idx_wide   = {1'b0, idx_ff};
      at         = socks5hp_pkg::atype_of(addr_code_ff);
      mode_eff   = mode_ff;

      if (accept) begin
         unique case (req_command)
            socks5hp_pkg::CMD_NEW: begin
               mode_in      = socks5hp_pkg::MODE_UNKNOWN;
               phase_in     = socks5hp_pkg::PH_GREETING;
               idx_in       = '0;
               methods_in   = '0;
               noauth_in    = 1'b0;
               req_kind_in  = '0;
               addr_code_in = '0;
               addr_size_in = '0;
               port_high_in = '0;
            end
            socks5hp_pkg::CMD_OUTCOME: begin
               if (mode_ff == socks5hp_pkg::MODE_SOCKS && phase_ff == socks5hp_pkg::PH_WAIT) begin
                  q_push = 1'b1;
                  if (req_connected) begin
                     q_action = make_act(socks5hp_pkg::OP_LONG, socks5hp_pkg::KIND_REPLY,
                                         16'd0, socks5hp_pkg::ATYPE_IPV4,
                                         socks5hp_pkg::REASON_NONE, socks5hp_pkg::REP_OK);
                     phase_in = socks5hp_pkg::PH_OPEN;
                  end else begin
                     q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE, socks5hp_pkg::KIND_REPLY,
                                         16'd0, socks5hp_pkg::ATYPE_IPV4,
                                         socks5hp_pkg::REASON_TUNNEL_FAIL,
                                         socks5hp_pkg::REP_UNREACH);
                     phase_in = socks5hp_pkg::PH_CLOSED;
                  end
               end
            end
            socks5hp_pkg::CMD_DATA: begin
               if (mode_ff == socks5hp_pkg::MODE_UNKNOWN) begin
                  mode_eff = (req_data_byte == socks5hp_pkg::SOCKS_VER) ?
                             socks5hp_pkg::MODE_SOCKS : socks5hp_pkg::MODE_DIVERT;
               end
               mode_in = mode_eff;
               if (mode_eff == socks5hp_pkg::MODE_DIVERT) begin
                  q_push   = 1'b1;
                  q_action = make_act(socks5hp_pkg::OP_SINGLE, socks5hp_pkg::KIND_DIVERTED,
                                      {8'd0, req_data_byte}, socks5hp_pkg::ATYPE_IPV4,
                                      socks5hp_pkg::REASON_NONE, 8'd0);
               end else begin
                  unique case (phase_ff)
                     socks5hp_pkg::PH_GREETING: begin
                        priority if (idx_ff == 9'd0) begin
                           if (req_data_byte != socks5hp_pkg::SOCKS_VER) begin
                              q_push   = 1'b1;
                              q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE,
                                                  socks5hp_pkg::KIND_REPLY, 16'd0,
                                                  socks5hp_pkg::ATYPE_IPV4,
                                                  socks5hp_pkg::REASON_BAD_GREETING,
                                                  socks5hp_pkg::REP_FAIL);
                              phase_in = socks5hp_pkg::PH_CLOSED;
                           end else begin
                              idx_in = idx_inc;
                           end
                        end else if (idx_ff == 9'd1) begin
                           if (req_data_byte == 8'd0) begin
                              q_push   = 1'b1;
                              q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE,
                                                  socks5hp_pkg::KIND_REPLY, 16'd0,
                                                  socks5hp_pkg::ATYPE_IPV4,
                                                  socks5hp_pkg::REASON_BAD_GREETING,
                                                  socks5hp_pkg::REP_FAIL);
                              phase_in = socks5hp_pkg::PH_CLOSED;
                           end else begin
                              methods_in = req_data_byte;
                              idx_in     = idx_inc;
                           end
                        end else begin
                           if (req_data_byte == socks5hp_pkg::METHOD_NOAUTH) begin
                              noauth_in = 1'b1;
                           end
                           methods_in = meth_dec;
                           if (meth_dec == 8'd0) begin
                              q_push = 1'b1;
                              if (noauth_ff || req_data_byte == socks5hp_pkg::METHOD_NOAUTH) begin
                                 q_action = make_act(socks5hp_pkg::OP_SHORT,
                                                     socks5hp_pkg::KIND_REPLY, 16'd0,
                                                     socks5hp_pkg::ATYPE_IPV4,
                                                     socks5hp_pkg::REASON_NONE,
                                                     socks5hp_pkg::METHOD_NOAUTH);
                                 phase_in = socks5hp_pkg::PH_REQUEST;
                                 idx_in   = '0;
                              end else begin
                                 q_action = make_act(socks5hp_pkg::OP_SHORT_CLOSE,
                                                     socks5hp_pkg::KIND_REPLY, 16'd0,
                                                     socks5hp_pkg::ATYPE_IPV4,
                                                     socks5hp_pkg::REASON_NO_AUTH,
                                                     socks5hp_pkg::REP_NOAUTH);
                                 phase_in = socks5hp_pkg::PH_CLOSED;
                              end
                           end else begin
                              idx_in = idx_inc;
                           end
                        end
                     end
                     socks5hp_pkg::PH_REQUEST: begin
                        priority if (idx_ff == 9'd0) begin
                           if (req_data_byte != socks5hp_pkg::SOCKS_VER) begin
                              q_push   = 1'b1;
                              q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE,
                                                  socks5hp_pkg::KIND_REPLY, 16'd0,
                                                  socks5hp_pkg::ATYPE_IPV4,
                                                  socks5hp_pkg::REASON_BAD_REQUEST,
                                                  socks5hp_pkg::REP_FAIL);
                              phase_in = socks5hp_pkg::PH_CLOSED;
                           end else begin
                              idx_in = idx_inc;
                           end
                        end else if (idx_ff == 9'd1) begin
                           req_kind_in = req_data_byte;
                           idx_in      = idx_inc;
                        end else if (idx_ff == 9'd2) begin
                           if (req_data_byte != 8'd0) begin
                              q_push   = 1'b1;
                              q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE,
                                                  socks5hp_pkg::KIND_REPLY, 16'd0,
                                                  socks5hp_pkg::ATYPE_IPV4,
                                                  socks5hp_pkg::REASON_BAD_REQUEST,
                                                  socks5hp_pkg::REP_FAIL);
                              phase_in = socks5hp_pkg::PH_CLOSED;
                           end else if (req_kind_ff != socks5hp_pkg::REQ_CONNECT) begin
                              q_push   = 1'b1;
                              q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE,
                                                  socks5hp_pkg::KIND_REPLY, 16'd0,
                                                  socks5hp_pkg::ATYPE_IPV4,
                                                  socks5hp_pkg::REASON_CMD_UNSUPP,
                                                  socks5hp_pkg::REP_CMD);
                              phase_in = socks5hp_pkg::PH_CLOSED;
                           end else begin
                              idx_in = idx_inc;
                           end
                        end else if (idx_ff == 9'd3) begin
                           addr_code_in = req_data_byte;
                           priority if (req_data_byte == socks5hp_pkg::ATYP_IPV4) begin
                              addr_size_in = socks5hp_pkg::IPV4_LEN;
                              idx_in       = idx_inc;
                           end else if (req_data_byte == socks5hp_pkg::ATYP_IPV6) begin
                              addr_size_in = socks5hp_pkg::IPV6_LEN;
                              idx_in       = idx_inc;
                           end else if (req_data_byte == socks5hp_pkg::ATYP_DOMAIN) begin
                              idx_in = idx_inc;
                           end else begin
                              q_push   = 1'b1;
                              q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE,
                                                  socks5hp_pkg::KIND_REPLY, 16'd0,
                                                  socks5hp_pkg::ATYPE_IPV4,
                                                  socks5hp_pkg::REASON_ATYPE_UNSUPP,
                                                  socks5hp_pkg::REP_ATYPE);
                              phase_in = socks5hp_pkg::PH_CLOSED;
                           end
                        end else if (idx_ff == 9'd4 &&
                                     addr_code_ff == socks5hp_pkg::ATYP_DOMAIN) begin
                           if (req_data_byte == 8'd0) begin
                              q_push   = 1'b1;
                              q_action = make_act(socks5hp_pkg::OP_LONG_CLOSE,
                                                  socks5hp_pkg::KIND_REPLY, 16'd0,
                                                  socks5hp_pkg::ATYPE_IPV4,
                                                  socks5hp_pkg::REASON_BAD_REQUEST,
                                                  socks5hp_pkg::REP_FAIL);
                              phase_in = socks5hp_pkg::PH_CLOSED;
                           end else begin
                              addr_size_in = req_data_byte;
                              idx_in       = idx_inc;
                           end
                        end else if (idx_wide < addr_end) begin
                           q_push   = 1'b1;
                           q_action = make_act(socks5hp_pkg::OP_SINGLE,
                                               socks5hp_pkg::KIND_ADDRESS,
                                               {8'd0, req_data_byte}, at,
                                               socks5hp_pkg::REASON_NONE, 8'd0);
                           idx_in   = idx_inc;
                        end else if (idx_wide == addr_end) begin
                           port_high_in = req_data_byte;
                           idx_in       = idx_inc;
                        end else begin
                           q_push   = 1'b1;
                           q_action = make_act(socks5hp_pkg::OP_SINGLE,
                                               socks5hp_pkg::KIND_TARGET,
                                               {port_high_ff, req_data_byte}, at,
                                               socks5hp_pkg::REASON_NONE, 8'd0);
                           phase_in = socks5hp_pkg::PH_WAIT;
                           idx_in   = '0;
                        end
                     end
                     socks5hp_pkg::PH_WAIT, socks5hp_pkg::PH_OPEN: begin
                        q_push   = 1'b1;
                        q_action = make_act(socks5hp_pkg::OP_SINGLE, socks5hp_pkg::KIND_PAYLOAD,
                                            {8'd0, req_data_byte}, socks5hp_pkg::ATYPE_IPV4,
                                            socks5hp_pkg::REASON_NONE, 8'd0);
                     end
                     default: begin
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/socks5hp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module socks5hp_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire socks5hp_pkg::action_type push_data,
   output logic                          full,
   output logic                          valid,
   output socks5hp_pkg::action_type      head,
   input  wire logic                     pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   socks5hp_pkg::action_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign valid   = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/socks5hp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module socks5hp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire socks5hp_pkg::action_type q_head,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [2:0]                    rsp_tuser,
   output logic [23:0]                   rsp_tdata,
   output logic                          rsp_tlast
);

   logic [3:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [2:0]  kind_ff;
   logic [15:0] value_ff;
   logic [1:0]  atype_ff;
   logic [2:0]  reason_ff;
   logic        last_ff;

   logic        load;
   logic        take;
   logic [3:0]  reply_n;
   logic        has_close;
   logic [7:0]  reply_byte;
   logic [2:0]  nx_kind;
   logic [15:0] nx_value;
   logic [1:0]  nx_atype;
   logic [2:0]  nx_reason;
   logic        nx_last;

   assign load  = !valid_ff || rsp_tready;
   assign take  = load && q_valid;
   assign q_pop = take && nx_last;

   always_comb begin
      reply_n   = socks5hp_pkg::LONG_LEN;
      has_close = 1'b0;
      unique case (q_head.op)
         socks5hp_pkg::OP_SHORT: begin
            reply_n = socks5hp_pkg::SHORT_LEN;
         end
         socks5hp_pkg::OP_SHORT_CLOSE: begin
            reply_n   = socks5hp_pkg::SHORT_LEN;
            has_close = 1'b1;
         end
         socks5hp_pkg::OP_LONG_CLOSE: begin
            has_close = 1'b1;
         end
         default: begin
         end
      endcase

      priority if (cnt_ff == 4'd0) begin
         reply_byte = socks5hp_pkg::SOCKS_VER;
      end else if (cnt_ff == 4'd1) begin
         reply_byte = q_head.code;
      end else if (cnt_ff == 4'd3) begin
         reply_byte = socks5hp_pkg::ATYP_IPV4;
      end else begin
         reply_byte = 8'd0;
      end

      if (q_head.op == socks5hp_pkg::OP_SINGLE) begin
         nx_kind   = q_head.kind;
         nx_value  = q_head.value;
         nx_atype  = q_head.atype;
         nx_reason = q_head.reason;
         nx_last   = 1'b1;
      end else if (cnt_ff < reply_n) begin
         nx_kind   = socks5hp_pkg::KIND_REPLY;
         nx_value  = {8'd0, reply_byte};
         nx_atype  = socks5hp_pkg::ATYPE_IPV4;
         nx_reason = socks5hp_pkg::REASON_NONE;
         nx_last   = (cnt_ff == reply_n - 4'd1) && !has_close;
      end else begin
         nx_kind   = socks5hp_pkg::KIND_CLOSED;
         nx_value  = 16'd0;
         nx_atype  = socks5hp_pkg::ATYPE_IPV4;
         nx_reason = q_head.reason;
         nx_last   = 1'b1;
      end

      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
         cnt_in   = nx_last ? 4'd0 : cnt_ff + 4'd1;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff   <= nx_kind;
         value_ff  <= nx_value;
         atype_ff  <= nx_atype;
         reason_ff <= nx_reason;
         last_ff   <= nx_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {3'b000, reason_ff, atype_ff, value_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/socks5_handshake_parser.sv =====
// socks5 server handshake parser
// req channel: one transaction per client event. tuser carries the command
// (data byte, new connection, tunnel outcome), tdata the byte and the
// tunnel-established flag. a new-connection command clears all parse state.
// rsp channel: result transactions; tuser is the result kind, tdata holds
// value, address type and close reason, tlast marks the final result that
// one request transaction caused. requests that cause no result give none.
// a front parser classifies each byte into a job written into the queue; with
// an empty queue the back sequencer then loads that job's first result into the
// output register; it expands jobs into results, one per cycle unless stalled.
// throughput: one request per cycle; a job yields 1, 2, 3, 10 or 11 results,
// so req_tready drops only while the job queue is full behind long replies.
// when the receiver holds rsp_tready low the output register holds its
// transaction, the back end pauses and the queue fills, then req_tready drops.
// reset (synchronous, active high) empties the queue and output register and
// returns the parser to the greeting phase with the protocol not yet known.
`timescale 1ns / 1ps
`default_nettype none
`include "socks5_handshake_parser_macros.svh"

module socks5_handshake_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // data_byte[7:0], connected[8], zero[15:9]
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // value[15:0], address_type[17:16],
                                         // close_reason[20:18], zero[23:21]
   output logic [2:0]       rsp_tuser,   // kind[2:0]
   output logic             rsp_tlast
);

   logic                     q_full;
   logic                     q_push;
   logic                     q_valid;
   logic                     q_pop;
   socks5hp_pkg::action_type q_action;
   socks5hp_pkg::action_type q_head;

   socks5hp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_command   (req_tuser),
      .req_data_byte (req_tdata[7:0]),
      .req_connected (req_tdata[8]),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_action      (q_action)
   );

   socks5hp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_action),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head),
      .pop       (q_pop)
   );

   socks5hp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `SOCKS5HP_ASSERT_NR(a_rst_idle, clock, reset |=> !rsp_tvalid, "output valid after reset")
   `SOCKS5HP_ASSERT(a_close_last, clock, reset, rsp_tvalid && rsp_tuser == socks5hp_pkg::KIND_CLOSED |-> rsp_tlast, "close result not last")
   `SOCKS5HP_ASSERT(a_atype_kind, clock, reset, rsp_tvalid && rsp_tuser != socks5hp_pkg::KIND_ADDRESS && rsp_tuser != socks5hp_pkg::KIND_TARGET |-> rsp_tdata[17:16] == 2'b00, "address type on wrong kind")
   `SOCKS5HP_ASSERT(a_pop_valid, clock, reset, q_pop |-> q_valid, "job popped from empty queue")

endmodule

`default_nettype wire
